// ===== hdl/triangle_barycentric_basis_macros.svh =====
// Assertion macros shared by the triangle barycentric basis design.
`ifndef TRIANGLE_BARYCENTRIC_BASIS_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_BASIS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TBB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TBB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tbb_pkg.sv =====
// Widths and constants of the triangle barycentric basis datapath.
`timescale 1ns / 1ps
package tbb_pkg;
    localparam int COORD_W    = 16;
    localparam int FRAC_W     = 8;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int AREA_W     = PROD_W + 1;
    localparam int LAM_SHIFT  = 16;
    localparam int GRAD_SHIFT = 2 * FRAC_W + 16 - FRAC_W;
    localparam int NUM_W      = AREA_W + LAM_SHIFT;
    localparam int Q_W        = 32;
    localparam int LAM_W      = 18;
    localparam int GRAD_W     = 32;
    localparam int DIV_LAT    = Q_W + 1;
    localparam int N_LAM      = 3;
    localparam int N_GRAD     = 6;
    localparam int N_LANE     = N_LAM + N_GRAD;
    localparam int IN_W       = 8 * COORD_W;
    localparam int OUT_BITS   = N_LAM * LAM_W + N_GRAD * GRAD_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;
endpackage

// ===== hdl/tbb_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module tbb_div (
    input  logic                       clk,
    input  logic                       adv,
    input  logic [tbb_pkg::NUM_W-1:0]  num,
    input  logic [tbb_pkg::AREA_W-1:0] den,
    output logic [tbb_pkg::Q_W-1:0]    quo,
    output logic                       ovf
);
    import tbb_pkg::*;

    logic [AREA_W-1:0] d_reg [0:Q_W];
    logic [AREA_W-1:0] r_reg [0:Q_W];
    logic [Q_W-1:0]    n_reg [0:Q_W];
    logic [Q_W-1:0]    q_reg [0:Q_W];
    logic              o_reg [0:Q_W];

    // entry stage: quotient fits in Q_W bits unless num >= den * 2^Q_W
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0] <= den;
            r_reg[0] <= AREA_W'(num[NUM_W-1:Q_W]);
            n_reg[0] <= num[Q_W-1:0];
            q_reg[0] <= '0;
            o_reg[0] <= {{Q_W{1'b0}}, num} >= {{(NUM_W-AREA_W){1'b0}}, den, {Q_W{1'b0}}};
        end
    end

    for (genvar s = 0; s < Q_W; s++)
    begin : g_step
        logic [AREA_W:0]   shifted;
        logic [AREA_W:0]   diff;
        logic              take;
        always_comb
        begin
            shifted = {r_reg[s], n_reg[s][Q_W-1]};
            diff    = shifted - {1'b0, d_reg[s]};
            take    = shifted >= {1'b0, d_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[s+1] <= d_reg[s];
                r_reg[s+1] <= take ? diff[AREA_W-1:0] : shifted[AREA_W-1:0];
                n_reg[s+1] <= {n_reg[s][Q_W-2:0], 1'b0};
                q_reg[s+1] <= {q_reg[s][Q_W-2:0], take};
                o_reg[s+1] <= o_reg[s];
            end
        end
    end

    assign quo = q_reg[Q_W];
    assign ovf = o_reg[Q_W];
endmodule

// ===== hdl/triangle_barycentric_basis.sv =====
// Top level of the triangle barycentric basis pipeline.
// Usage:
//   s_axis carries one item per handshake: a point and three triangle vertices,
//   each signed Q8.8. m_axis returns one item per input: three barycentric
//   coordinates (signed Q2.16, saturated), six basis gradients (signed Q16.16,
//   saturated) in tdata, and the degenerate flag in tuser.
//   From input handshake to output valid an item passes one stage of
//   coordinate differences, one of 17x17 products, one of area subtraction,
//   one of magnitude and sign extraction, 33 divider stages (overflow check
//   plus one quotient bit per stage) and the output saturation register.
//   Throughput is one item per cycle without stalls; nine dividers run side
//   by side, one per output value, all sharing the twice-area denominator.
//   A zero area raises the degenerate flag and forces every value to zero.
//   Reset clears only the valid bits; the datapath carries no state.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready drops in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "triangle_barycentric_basis_macros.svh"
module triangle_barycentric_basis (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // px, py, v0x, v0y, v1x, v1y, v2x, v2y, COORD_W bits each, lowest first
    input  logic [tbb_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // lambda_first, lambda_second, lambda_third (18b each), grad_first_x,
    // grad_first_y, grad_second_x, grad_second_y, grad_third_x,
    // grad_third_y (32b each), zero fill to a whole byte
    output logic [tbb_pkg::OUT_W-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0]                m_axis_tuser
);
    import tbb_pkg::*;

    localparam int VLD_N = 5 + DIV_LAT;
    localparam logic [Q_W:0] LAM_LIM  = {{(Q_W-LAM_W+2){1'b0}}, {(LAM_W-1){1'b1}}};
    localparam logic [Q_W:0] GRAD_LIM = {{(Q_W-GRAD_W+2){1'b0}}, {(GRAD_W-1){1'b1}}};

    // Truncated quotient magnitude -> saturated two's complement value.
    function automatic logic [Q_W-1:0] sat_q(input logic [Q_W-1:0] q, input logic o,
                                             input logic neg, input logic [Q_W:0] lim_pos);
        logic [Q_W:0] lim;
        logic [Q_W:0] qv;
        logic [Q_W:0] res;
        lim = neg ? lim_pos + 1'b1 : lim_pos;
        qv  = (o || ({1'b0, q} > lim)) ? lim : {1'b0, q};
        res = neg ? (~qv + 1'b1) : qv;
        return res[Q_W-1:0];
    endfunction

    // valid bit of each stage: 0..3 front, 4..4+DIV_LAT-1 divider, last = output
    logic [VLD_N-1:0] vld_reg;
    logic             advance;

    assign advance       = !vld_reg[VLD_N-1] || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = vld_reg[VLD_N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[VLD_N-2:0], s_axis_tvalid};
        end
    end

    // ---------------- stage 1: coordinate differences ----------------
    logic [DIFF_W-1:0] px, py, x0, y0, x1, y1, x2, y2;
    logic signed [DIFF_W-1:0] dif_next [0:9];
    logic signed [DIFF_W-1:0] edg_next [0:N_GRAD-1];
    logic signed [DIFF_W-1:0] dif_reg  [0:9];
    logic signed [DIFF_W-1:0] edg1_reg [0:N_GRAD-1];

    always_comb
    begin
        // sign-extend each coordinate by one bit so every difference is exact
        px = {s_axis_tdata[1*COORD_W-1], s_axis_tdata[0*COORD_W +: COORD_W]};
        py = {s_axis_tdata[2*COORD_W-1], s_axis_tdata[1*COORD_W +: COORD_W]};
        x0 = {s_axis_tdata[3*COORD_W-1], s_axis_tdata[2*COORD_W +: COORD_W]};
        y0 = {s_axis_tdata[4*COORD_W-1], s_axis_tdata[3*COORD_W +: COORD_W]};
        x1 = {s_axis_tdata[5*COORD_W-1], s_axis_tdata[4*COORD_W +: COORD_W]};
        y1 = {s_axis_tdata[6*COORD_W-1], s_axis_tdata[5*COORD_W +: COORD_W]};
        x2 = {s_axis_tdata[7*COORD_W-1], s_axis_tdata[6*COORD_W +: COORD_W]};
        y2 = {s_axis_tdata[8*COORD_W-1], s_axis_tdata[7*COORD_W +: COORD_W]};
        dif_next[0] = x1 - x0;
        dif_next[1] = y2 - y0;
        dif_next[2] = y1 - y0;
        dif_next[3] = x2 - x0;
        dif_next[4] = x1 - px;
        dif_next[5] = y2 - py;
        dif_next[6] = y1 - py;
        dif_next[7] = x2 - px;
        dif_next[8] = px - x0;
        dif_next[9] = py - y0;
        // edge normals, in output order
        edg_next[0] = y1 - y2;
        edg_next[1] = x2 - x1;
        edg_next[2] = y2 - y0;
        edg_next[3] = x0 - x2;
        edg_next[4] = y0 - y1;
        edg_next[5] = x1 - x0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dif_reg  <= dif_next;
            edg1_reg <= edg_next;
        end
    end

    // ---------------- stage 2: products ----------------
    // pairs 0/1 area, 2/3 first sub-area, 4/5 second, 6/7 third
    logic signed [PROD_W-1:0] prd_reg  [0:7];
    logic signed [DIFF_W-1:0] edg2_reg [0:N_GRAD-1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prd_reg[0] <= PROD_W'(dif_reg[0]) * PROD_W'(dif_reg[1]);
            prd_reg[1] <= PROD_W'(dif_reg[2]) * PROD_W'(dif_reg[3]);
            prd_reg[2] <= PROD_W'(dif_reg[4]) * PROD_W'(dif_reg[5]);
            prd_reg[3] <= PROD_W'(dif_reg[6]) * PROD_W'(dif_reg[7]);
            prd_reg[4] <= PROD_W'(dif_reg[8]) * PROD_W'(dif_reg[1]);
            prd_reg[5] <= PROD_W'(dif_reg[9]) * PROD_W'(dif_reg[3]);
            prd_reg[6] <= PROD_W'(dif_reg[0]) * PROD_W'(dif_reg[9]);
            prd_reg[7] <= PROD_W'(dif_reg[2]) * PROD_W'(dif_reg[8]);
            edg2_reg   <= edg1_reg;
        end
    end

    // ---------------- stage 3: areas ----------------
    logic signed [AREA_W-1:0] area_reg;
    logic signed [AREA_W-1:0] sub_reg  [0:N_LAM-1];
    logic signed [DIFF_W-1:0] edg3_reg [0:N_GRAD-1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            area_reg <= AREA_W'(prd_reg[0]) - AREA_W'(prd_reg[1]);
            for (int k = 0; k < N_LAM; k++)
            begin
                sub_reg[k] <= AREA_W'(prd_reg[2+2*k]) - AREA_W'(prd_reg[3+2*k]);
            end
            edg3_reg <= edg2_reg;
        end
    end

    // ---------------- stage 4: magnitudes, signs, numerators ----------------
    logic [AREA_W-1:0] den_next;
    logic [NUM_W-1:0]  num_next [0:N_LANE-1];
    logic [N_LANE-1:0] neg_next;
    logic [AREA_W-1:0] smag;
    logic [DIFF_W-1:0] emag;

    logic [AREA_W-1:0] den_reg;
    logic [NUM_W-1:0]  num_reg [0:N_LANE-1];
    logic [N_LANE-1:0] neg4_reg;
    logic              deg4_reg;

    always_comb
    begin
        smag     = '0;
        emag     = '0;
        den_next = area_reg[AREA_W-1] ? AREA_W'(-area_reg) : AREA_W'(area_reg);
        for (int k = 0; k < N_LAM; k++)
        begin
            smag        = sub_reg[k][AREA_W-1] ? AREA_W'(-sub_reg[k]) : AREA_W'(sub_reg[k]);
            num_next[k] = {smag, {LAM_SHIFT{1'b0}}};
            neg_next[k] = sub_reg[k][AREA_W-1] ^ area_reg[AREA_W-1];
        end
        for (int k = 0; k < N_GRAD; k++)
        begin
            emag = edg3_reg[k][DIFF_W-1] ? DIFF_W'(-edg3_reg[k]) : DIFF_W'(edg3_reg[k]);
            num_next[N_LAM+k] = NUM_W'({emag, {GRAD_SHIFT{1'b0}}});
            neg_next[N_LAM+k] = edg3_reg[k][DIFF_W-1] ^ area_reg[AREA_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            den_reg  <= den_next;
            num_reg  <= num_next;
            neg4_reg <= neg_next;
            deg4_reg <= (area_reg == '0);
        end
    end

    // ---------------- divider stages ----------------
    logic [Q_W-1:0]    quo  [0:N_LANE-1];
    logic [N_LANE-1:0] ovf;

    for (genvar k = 0; k < N_LANE; k++)
    begin : g_lane
        tbb_div u_div (
            .clk (clk),
            .adv (advance),
            .num (num_reg[k]),
            .den (den_reg),
            .quo (quo[k]),
            .ovf (ovf[k])
        );
    end

    // carry sign and degenerate flag alongside the divider
    logic [N_LANE-1:0] neg_pipe_reg [0:DIV_LAT-1];
    logic              deg_pipe_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            neg_pipe_reg[0] <= neg4_reg;
            deg_pipe_reg[0] <= deg4_reg;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                neg_pipe_reg[s] <= neg_pipe_reg[s-1];
                deg_pipe_reg[s] <= deg_pipe_reg[s-1];
            end
        end
    end

    // ---------------- output stage: saturate, pack ----------------
    logic [OUT_W-1:0] data_next;
    logic [Q_W-1:0]   sat_val;
    logic [OUT_W-1:0] data_reg;
    logic             deg_reg;

    always_comb
    begin
        data_next = '0;
        sat_val   = '0;
        for (int k = 0; k < N_LAM; k++)
        begin
            sat_val = sat_q(quo[k], ovf[k], neg_pipe_reg[DIV_LAT-1][k], LAM_LIM);
            data_next[k*LAM_W +: LAM_W] = sat_val[LAM_W-1:0];
        end
        for (int k = 0; k < N_GRAD; k++)
        begin
            sat_val = sat_q(quo[N_LAM+k], ovf[N_LAM+k], neg_pipe_reg[DIV_LAT-1][N_LAM+k],
                            GRAD_LIM);
            data_next[N_LAM*LAM_W + k*GRAD_W +: GRAD_W] = sat_val[GRAD_W-1:0];
        end
        // zero area: the quotients are meaningless, drop them
        if (deg_pipe_reg[DIV_LAT-1])
        begin
            data_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
            deg_reg  <= deg_pipe_reg[DIV_LAT-1];
        end
    end

    assign m_axis_tdata    = data_reg;
    assign m_axis_tuser[0] = deg_reg;

    // ---------------- checks ----------------
    `TBB_ASSERT_IMP(a_deg_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "degenerate item carries nonzero values")
    `TBB_ASSERT_NXT(a_stall_hold, !advance, $stable(vld_reg), "pipeline valid bits moved during a stall")
    `TBB_ASSERT_NXT(a_accept_enter, s_axis_tvalid && s_axis_tready, vld_reg[0], "accepted item missing from first stage")
endmodule
